[hdl/double_ended_queue_core_macros.svh]
// assertion macros for the double-ended queue core
// expects clk and rst_n in the scope where a macro is used
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DQ_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dq_pkg.sv]
// shared types and constants for the double-ended queue core
// no dependencies
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } dq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } dq_out_t;

  typedef struct packed {
    logic                  shift_in_front;
    logic                  shift_to_front;
    logic                  write_back;
    logic [IDX_W-1:0]      slot;
    logic [DATA_WIDTH-1:0] word;
  } dq_cell_ctrl_t;

endpackage

[hdl/dq_cell.sv]
// one storage cell of the deque row, holds one entry
// depends on dq_pkg
module dq_cell import dq_pkg::*; (
  input  logic                  clk,
  input  dq_cell_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]      cell_idx,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tap
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit;

  assign hit = (cell_idx == ctrl.slot);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_in_front) begin
      data_nxt = left_data;
    end else if (ctrl.shift_to_front) begin
      data_nxt = right_data;
    end else if (ctrl.write_back && hit) begin
      data_nxt = ctrl.word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap  = hit ? data_r : '0;

endmodule

[hdl/double_ended_queue_core.sv]
// top level of the double-ended queue core: count, decode and result register
// depends on dq_pkg, dq_cell and double_ended_queue_core_macros.svh
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   in_req carries the command and the push word; commands 0..5 are push
//   front, push back, pop front, pop back, peek front, peek back.
//   Entries live in a row of DEPTH cells with the front at cell 0: a push at
//   the front or a pop at the front shifts the whole row by one cell, a push
//   at the back writes the cell at the current count, and back reads take
//   the cell at count minus one.
//   Latency: the result appears on out_rsp with out_valid high for exactly
//   one cycle, the cycle after the request is taken.
//   Throughput: one request per cycle; busy stays low, since every command
//   is a single row update plus a count step.
//   Reset: synchronous, active low; the deque is empty afterwards.
//   The receiver cannot stall: out_valid is a strobe and each result must be
//   taken in the cycle it is shown.
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core import dq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dq_in_t  in_req,
  output logic    out_valid,
  output dq_out_t out_rsp
);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  dq_out_t               out_rsp_r;
  dq_out_t               rsp_nxt;
  dq_cell_ctrl_t         ctrl;
  logic                  accept;
  logic                  empty;
  logic                  full;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] back_data;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [CNT_W-1:0]      count_dec;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign count_dec = count_r - CNT_W'(1);

  always_comb begin
    ctrl                = '0;
    ctrl.word           = DATA_WIDTH'(in_req.push_value);
    ctrl.slot           = count_dec[IDX_W-1:0];
    count_nxt           = count_r;
    rsp_nxt             = '0;
    rsp_nxt.status      = ST_OK;
    case (in_req.cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          ctrl.shift_in_front = accept;
          count_nxt           = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        ctrl.slot = count_r[IDX_W-1:0];
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          ctrl.write_back = accept;
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.read_value  = 32'(front_data);
          ctrl.shift_to_front = accept;
          count_nxt           = count_dec;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.read_value = 32'(back_data);
          count_nxt          = count_dec;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.read_value = 32'(front_data);
        end
      end
      CMD_PEEK_BACK: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.read_value = 32'(back_data);
        end
      end
      default: begin
        rsp_nxt.status = ST_OK;
      end
    endcase
    rsp_nxt.occupancy = 5'(count_nxt);
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_in;
      logic [DATA_WIDTH-1:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = ctrl.word;
      end else begin : g_mid_l
        assign left_in = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_data[gi+1];
      end
      dq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .cell_idx   (IDX_W'(gi)),
        .left_data  (left_in),
        .right_data (right_in),
        .data       (cell_data[gi]),
        .tap        (cell_tap[gi])
      );
    end
  endgenerate

  assign front_data = cell_data[0];

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `DQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `DQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "request without result")
  `DQ_ASSERT_NEXT(a_count_idle, !accept, $stable(count_r), "count moved while idle")
  `DQ_ASSERT_SAME(a_full_occ, out_valid && out_rsp.status == ST_FULL, out_rsp.occupancy == 5'(DEPTH) && out_rsp.read_value == '0, "full status mismatch")
  `DQ_ASSERT_SAME(a_empty_occ, out_valid && out_rsp.status == ST_EMPTY, out_rsp.occupancy == '0 && out_rsp.read_value == '0, "empty status mismatch")

endmodule

[dv/double_ended_queue_core_tb.sv]
// self-checking testbench for double_ended_queue_core: directed table, then shaped random requests
// predicts every response with a behavioral deque and compares each field on the out_valid strobe
// depends on dq_pkg and the double_ended_queue_core rtl
module double_ended_queue_core_tb;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 800;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] word;
    int          reps;
    bit          typed;
    dq_out_t     want;
  } stim_row_t;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  dq_in_t  in_req;
  logic    out_valid;
  dq_out_t out_rsp;

  bit      row_typed;
  dq_out_t row_want;

  logic [DATA_WIDTH-1:0] deque_slots [DEPTH];
  int unsigned deque_front;
  int unsigned deque_back;
  int unsigned deque_count;

  dq_out_t   pending_results [$];
  stim_row_t directed_rows [$];

  int n_failures;
  int n_checked;
  int n_accepted;
  int n_full_seen;
  int n_empty_seen;
  int cycle_count;
  bit idle_enabled;

  double_ended_queue_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned slot_after(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned slot_before(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic dq_out_t predict_response(dq_in_t r);
    dq_out_t rsp;
    logic [DATA_WIDTH-1:0] word;
    rsp = '0;
    word = r.push_value[DATA_WIDTH-1:0];
    case (r.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (r.cmd == CMD_PUSH_FRONT) begin
          deque_front = slot_before(deque_front);
          deque_slots[deque_front] = word;
          deque_count++;
        end else begin
          deque_slots[deque_back] = word;
          deque_back = slot_after(deque_back);
          deque_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (deque_count == 0) begin
          rsp.status = ST_EMPTY;
        end else if (r.cmd == CMD_POP_FRONT) begin
          rsp.read_value = 32'(deque_slots[deque_front]);
          deque_front = slot_after(deque_front);
          deque_count--;
        end else if (r.cmd == CMD_POP_BACK) begin
          deque_back = slot_before(deque_back);
          rsp.read_value = 32'(deque_slots[deque_back]);
          deque_count--;
        end else if (r.cmd == CMD_PEEK_FRONT) begin
          rsp.read_value = 32'(deque_slots[deque_front]);
        end else begin
          rsp.read_value = 32'(deque_slots[slot_before(deque_back)]);
        end
      end
      default: ;
    endcase
    rsp.occupancy = 5'(deque_count);
    return rsp;
  endfunction

  task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
    n_failures++;
    if (n_failures <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
               cycle_count, field, want, got);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    dq_out_t want;
    dq_out_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected response, read_value", 0, out_rsp.read_value);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_rsp.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, out_rsp.read_value);
          if (out_rsp.status !== want.status)
            report_mismatch("status", want.status, out_rsp.status);
          if (out_rsp.occupancy !== want.occupancy)
            report_mismatch("occupancy", want.occupancy, out_rsp.occupancy);
        end
      end
      if (start && !busy) begin
        pred = predict_response(in_req);
        n_accepted++;
        if (pred.status == ST_FULL) n_full_seen++;
        if (pred.status == ST_EMPTY) n_empty_seen++;
        pending_results.push_back(row_typed ? row_want : pred);
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(dq_in_t r, bit typed, dq_out_t want);
    dq_in_t junk;
    if (idle_enabled && $urandom_range(0, 99) < 9) begin
      junk.cmd = 3'($urandom);
      junk.push_value = $urandom;
      start  <= 1'b0;
      in_req <= junk;
      @(negedge clk);
    end
    start     <= 1'b1;
    in_req    <= r;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(logic [2:0] cmd, logic [31:0] word, int reps, bit typed,
                         logic [31:0] rd, logic [1:0] st, logic [4:0] occ);
    stim_row_t row;
    row.cmd   = cmd;
    row.word  = word;
    row.reps  = reps;
    row.typed = typed;
    row.want  = {rd, st, occ};
    directed_rows.push_back(row);
  endtask

  function automatic logic [2:0] pick_cmd(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    case (mode)
      0: return (roll < 85) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 5));
      1: return (roll < 85) ? 3'($urandom_range(2, 3)) : 3'($urandom_range(0, 5));
      2: return (roll < 60) ? 3'($urandom_range(4, 5)) : 3'($urandom_range(0, 3));
      default: return 3'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin
    dq_in_t req;
    int n_random;
    int mode;
    int mode_left;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    row_typed    = 1'b0;
    row_want     = '0;
    deque_front  = 0;
    deque_back   = 0;
    deque_count  = 0;
    idle_enabled = 1'b1;

    // empty deque, unused commands, both ends, then fill to full, push while full and read both ends
    add_row(CMD_POP_FRONT,  32'h0,         1, 1, 32'h0,         ST_EMPTY, 5'd0);
    add_row(CMD_POP_BACK,   32'h0,         1, 1, 32'h0,         ST_EMPTY, 5'd0);
    add_row(CMD_PEEK_FRONT, 32'h0,         1, 1, 32'h0,         ST_EMPTY, 5'd0);
    add_row(CMD_PEEK_BACK,  32'hFFFF_FFFF, 1, 1, 32'h0,         ST_EMPTY, 5'd0);
    add_row(CMD_UNUSED_6,   32'hFFFF_FFFF, 1, 1, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_UNUSED_7,   32'h0,         1, 1, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 32'h0,         ST_OK,    5'd1);
    add_row(CMD_PUSH_BACK,  32'h0,         1, 1, 32'h0,         ST_OK,    5'd2);
    add_row(CMD_PEEK_FRONT, 32'h0,         1, 1, 32'hFFFF_FFFF, ST_OK,    5'd2);
    add_row(CMD_PEEK_BACK,  32'h0,         1, 1, 32'h0,         ST_OK,    5'd2);
    add_row(CMD_PUSH_FRONT, 32'h8000_0001, 7, 0, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_PUSH_BACK,  32'h7FFF_FFFE, 7, 0, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_PUSH_BACK,  32'h1234_5678, 1, 1, 32'h0,         ST_FULL,  5'd16);
    add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 32'h0,         ST_FULL,  5'd16);
    add_row(CMD_PEEK_FRONT, 32'h0,         1, 0, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_PEEK_BACK,  32'h0,         1, 0, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_POP_BACK,   32'h0,         1, 0, 32'h0,         ST_OK,    5'd0);
    add_row(CMD_POP_FRONT,  32'h0,         1, 0, 32'h0,         ST_OK,    5'd0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        req.cmd        = directed_rows[i].cmd;
        req.push_value = directed_rows[i].word;
        send_request(req, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    wait_for_drain();

    n_random  = 0;
    mode      = 0;
    mode_left = 0;
    while (n_random < RANDOM_REQUESTS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;
      idle_enabled = !(n_random >= 300 && n_random < 500);
      if (n_random == 550) wait_for_drain();
      req.cmd        = pick_cmd(mode);
      req.push_value = pick_word();
      send_request(req, 1'b0, '0);
      if (req.cmd <= CMD_PEEK_BACK) n_random++;
    end
    wait_for_drain();
    repeat (3) @(posedge clk);

    n_failures += pending_results.size();
    $display("covered %0d requests, %0d responses checked", n_accepted, n_checked);
    $display("full pushes %0d, empty pops or peeks %0d, failures %0d",
             n_full_seen, n_empty_seen, n_failures);
    if (n_failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[double_ended_queue_core.f]
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
